// ===== rtl/core/gap_limited_max_sum_dp_core_macros.svh =====
// assertion macros shared by the gap-limited max-sum core
// no dependencies; included by the files that carry assertions
`ifndef GAP_LIMITED_MAX_SUM_DP_CORE_MACROS_SVH
`define GAP_LIMITED_MAX_SUM_DP_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GLMSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define GLMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/glmsd_pkg.sv =====
// package for the gap-limited max-sum core: sizes, register map, cell control
// no dependencies; used by glmsd_cell and gap_limited_max_sum_dp_core
package glmsd_pkg;

	localparam int WIN      = 64;
	localparam int GAP_W    = $clog2(WIN + 1);
	localparam int CFG_W    = 7;
	localparam int VAL_W    = 32;
	localparam int SCORE_W  = 48;
	localparam int BEST_W   = 47;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [ADDR_W-1:0] REG_MAX_GAP_ADDR = ADDR_W'(0);
	localparam logic [CFG_W-1:0]  MAX_GAP_RESET    = CFG_W'(1);

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic logic [GAP_W-1:0] eff_gap(input logic [CFG_W-1:0] mg);
		int g;
		g = int'(mg);
		if (g < 1)
			g = 1;
		if (g > WIN)
			g = WIN;
		return GAP_W'(g);
	endfunction

endpackage

// ===== rtl/core/glmsd_cell.sv =====
// one window cell: holds a stored score and a registered partial maximum
// depends on glmsd_pkg
module glmsd_cell
	import glmsd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cell_ctrl_t                ctrl,
	input  logic [GAP_W-1:0]          idx,
	input  logic [GAP_W-1:0]          lim,
	input  logic signed [SCORE_W-1:0] score_in,
	input  logic signed [SCORE_W-1:0] pmax_in,
	output logic signed [SCORE_W-1:0] score_out,
	output logic signed [SCORE_W-1:0] pmax_out
);

	logic signed [SCORE_W-1:0] score_q;
	logic signed [SCORE_W-1:0] pmax_q;
	logic                      take;

	assign take = (idx < lim) && (score_q > pmax_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			pmax_q  <= '0;
		end else begin
			if (ctrl.clear) begin
				score_q <= '0;
			end else if (ctrl.shift) begin
				score_q <= score_in;
			end
			pmax_q <= take ? score_q : pmax_in;
		end
	end

	assign score_out = score_q;
	assign pmax_out  = pmax_q;

endmodule

// ===== rtl/core/gap_limited_max_sum_dp_core.sv =====
// top level of the gap-limited max-sum core: stream ports, register port, cell row
// depends on glmsd_pkg, glmsd_cell and gap_limited_max_sum_dp_core_macros.svh
//
// Usage
//   Input stream s_*: s_tdata carries the signed 32-bit value, s_tuser flags
//   the first item of a new sequence (clears window and running best).
//   Output stream m_*: one result per item, chain score and running best.
//   Register port: max_gap at byte address 0, user must write only while idle (not enforced).
// Timing
//   An accepted request waits in the input stage, and its result is
//   registered once the output register is free or being read. The
//   window is a row of 64 cells; a partial maximum moves one cell per
//   cycle, so after each result the row must settle before the next
//   request is taken. A max_gap write also restarts the settle.
// Reset
//   Asynchronous, active low: window cleared, running best zero,
//   max_gap 1, no result pending, row settled at once.
// Stall
//   A result waits in the output register while m_tready is low; one more
//   request may be taken once the row settles, and it holds in the input
//   stage until the pending result leaves, which holds off any further one.
`include "gap_limited_max_sum_dp_core_macros.svh"
module gap_limited_max_sum_dp_core
	import glmsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [VAL_W-1:0]  s_tdata,   // [31:0] value
	input  logic              s_tuser,   // [0] start_new
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [95:0]       m_tdata,   // [47:0] chain_score, [94:48] best_score, [95] zero
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [CFG_W-1:0]          max_gap_q;
	logic [GAP_W-1:0]          settle_q;
	logic [GAP_W-1:0]          lim;
	logic                      cfg_wr;
	logic                      accept;
	logic                      commit;
	logic                      settled;

	logic                      busy_s1;
	logic signed [VAL_W-1:0]   val_s1;
	logic                      start_s1;

	logic                      out_valid_q;
	logic signed [SCORE_W-1:0] out_chain_q;
	logic [BEST_W-1:0]         out_best_q;
	logic [BEST_W-1:0]         best_q;

	logic signed [SCORE_W-1:0] wmax;
	logic signed [SCORE_W:0]   sum;
	logic signed [SCORE_W-1:0] chain;
	logic [BEST_W-1:0]         best_base;
	logic [BEST_W-1:0]         best_next;

	logic signed [SCORE_W-1:0] score_w [WIN];
	logic signed [SCORE_W-1:0] pmax_w  [WIN];
	cell_ctrl_t                ctrl_w  [WIN];

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_MAX_GAP_ADDR);
	assign prdata = (paddr == REG_MAX_GAP_ADDR) ? DATA_W'(max_gap_q) : '0;
	assign lim    = eff_gap(max_gap_q);

	// handshakes
	assign settled  = (settle_q == GAP_W'(WIN));
	assign s_tready = !busy_s1 && settled;
	assign accept   = s_tvalid && s_tready;
	assign commit   = busy_s1 && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_best_q, out_chain_q};

	// score of the current item
	always_comb begin
		wmax = start_s1 ? '0 : pmax_w[WIN-1];
		sum  = (SCORE_W+1)'(val_s1) + (SCORE_W+1)'(wmax);
		if (!sum[SCORE_W] && sum[SCORE_W-1])
			chain = SCORE_MAX;
		else
			chain = sum[SCORE_W-1:0];
		best_base = start_s1 ? '0 : best_q;
		if (!chain[SCORE_W-1] && (chain[BEST_W-1:0] > best_base))
			best_next = chain[BEST_W-1:0];
		else
			best_next = best_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q   <= MAX_GAP_RESET;
			settle_q    <= GAP_W'(WIN);
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			best_q      <= '0;
		end else begin
			if (cfg_wr)
				max_gap_q <= pwdata[CFG_W-1:0];
			if (cfg_wr || commit)
				settle_q <= '0;
			else if (!settled)
				settle_q <= settle_q + GAP_W'(1);
			if (accept)
				busy_s1 <= 1'b1;
			else if (commit)
				busy_s1 <= 1'b0;
			if (commit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (commit)
				best_q <= best_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1   <= s_tdata;
			start_s1 <= s_tuser;
		end
		if (commit) begin
			out_chain_q <= chain;
			out_best_q  <= best_next;
		end
	end

	// row of window cells, newest score in cell 0
	for (genvar i = 0; i < WIN; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign ctrl_w[i] = '{shift: commit, clear: 1'b0};
			glmsd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl_w[i]),
				.idx      (GAP_W'(i)),
				.lim      (lim),
				.score_in (chain),
				.pmax_in  ('0),
				.score_out(score_w[i]),
				.pmax_out (pmax_w[i])
			);
		end else begin : g_body
			assign ctrl_w[i] = '{shift: commit, clear: commit && start_s1};
			glmsd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl_w[i]),
				.idx      (GAP_W'(i)),
				.lim      (lim),
				.score_in (score_w[i-1]),
				.pmax_in  (pmax_w[i-1]),
				.score_out(score_w[i]),
				.pmax_out (pmax_w[i])
			);
		end
	end

	`GLMSD_ASSERT_NOW(a_accept_settled, clk, arst_n, accept, settled && !busy_s1)
	`GLMSD_ASSERT_NEXT(a_commit_restarts, clk, arst_n, commit, settle_q == '0)
	`GLMSD_ASSERT_NEXT(a_commit_shows, clk, arst_n, commit, out_valid_q && !busy_s1)
	`GLMSD_ASSERT_NOW(a_best_covers, clk, arst_n, out_valid_q && !out_chain_q[SCORE_W-1],
		out_best_q >= out_chain_q[BEST_W-1:0])

endmodule

// ===== test/gap_limited_max_sum_dp_core_tb.sv =====
// self-checking testbench for gap_limited_max_sum_dp_core: directed rows, then random phases
// depends on glmsd_pkg and the core; scores each request with its own window predictor
module gap_limited_max_sum_dp_core_tb;
	import glmsd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS = 50;
	localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = ADDR_W'(4);

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [ADDR_W-1:0]   addr;
		logic [31:0]         data;
		logic                start;
		logic                typed;
		logic [SCORE_W-1:0]  chain;
		logic [BEST_W-1:0]   best;
	} stim_row_t;

	typedef struct {
		logic [SCORE_W-1:0] chain;
		logic [BEST_W-1:0]  best;
	} score_pair_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [VAL_W-1:0]  s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [95:0]       m_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	gap_limited_max_sum_dp_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	logic signed [SCORE_W-1:0] score_window [WIN];
	int                        window_fill;
	logic signed [SCORE_W-1:0] best_so_far;
	logic [CFG_W-1:0]          gap_reg;

	score_pair_t pending_scores [$];
	stim_row_t   directed_rows [$];
	int          errors;
	int          cycles;
	int          items_sent;
	int          results_checked;
	int          writes_done;
	int          seq_starts;
	logic        calm;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_scores.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic void clear_sequence();
		for (int i = 0; i < WIN; i++)
			score_window[i] = '0;
		window_fill = 0;
		best_so_far = '0;
	endfunction

	function automatic score_pair_t score_item(input logic start, input logic [VAL_W-1:0] value);
		score_pair_t               res;
		logic signed [63:0]        v;
		logic signed [63:0]        wmax;
		logic signed [63:0]        sum;
		logic signed [SCORE_W-1:0] chain;
		int                        span;
		if (start)
			clear_sequence();
		v = {{32{value[VAL_W-1]}}, value};
		wmax = '0;
		span = int'(gap_reg);
		if (span < 1)
			span = 1;
		if (span > WIN)
			span = WIN;
		if (span > window_fill)
			span = window_fill;
		for (int i = 0; i < span; i++)
			if (64'(score_window[i]) > wmax)
				wmax = 64'(score_window[i]);
		sum = v + wmax;
		if (sum > SCORE_MAX)
			sum = SCORE_MAX;
		chain = sum[SCORE_W-1:0];
		for (int i = WIN - 1; i > 0; i--)
			score_window[i] = score_window[i-1];
		score_window[0] = chain;
		if (window_fill < WIN)
			window_fill++;
		if (chain > best_so_far)
			best_so_far = chain;
		res.chain = chain;
		res.best = best_so_far[BEST_W-1:0];
		return res;
	endfunction

	function automatic stim_row_t item_row(input logic start, input logic [31:0] value);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.addr = '0;
		r.data = value;
		r.start = start;
		r.typed = 1'b0;
		r.chain = '0;
		r.best = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic start, input logic [31:0] value,
		input logic [SCORE_W-1:0] chain, input logic [BEST_W-1:0] best);
		stim_row_t r;
		r = item_row(start, value);
		r.typed = 1'b1;
		r.chain = chain;
		r.best = best;
		return r;
	endfunction

	function automatic stim_row_t write_row(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		stim_row_t r;
		r = item_row(1'b0, data);
		r.kind = ROW_WRITE;
		r.addr = addr;
		return r;
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic start, input logic [VAL_W-1:0] value,
		input logic typed, input score_pair_t typed_exp);
		int          gap;
		score_pair_t pred;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= start;
		s_tdata <= value;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		pred = score_item(start, value);
		pending_scores.push_back(typed ? typed_exp : pred);
		items_sent++;
		if (start)
			seq_starts++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_MAX_GAP_ADDR)
			gap_reg = data[CFG_W-1:0];
		writes_done++;
	endtask

	// result side
	initial begin
		int          stall;
		score_pair_t exp_pair;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			if (pending_scores.size() == 0) begin
				report_mismatch($sformatf("result with no request waiting, data %h", m_tdata));
			end else begin
				exp_pair = pending_scores.pop_front();
				results_checked++;
				if (m_tdata[SCORE_W-1:0] !== exp_pair.chain)
					report_mismatch($sformatf("chain_score got %h expected %h",
						m_tdata[SCORE_W-1:0], exp_pair.chain));
				if (m_tdata[SCORE_W+BEST_W-1:SCORE_W] !== exp_pair.best)
					report_mismatch($sformatf("best_score got %h expected %h",
						m_tdata[SCORE_W+BEST_W-1:SCORE_W], exp_pair.best));
				if (m_tdata[95] !== 1'b0)
					report_mismatch("pad bit of m_tdata not zero");
			end
			@(negedge clk);
		end
	end

	// request side
	initial begin
		stim_row_t        row;
		score_pair_t      tp;
		logic [CFG_W-1:0] gapv;
		logic [31:0]      wdata;
		logic [31:0]      value;
		int               start_odds;
		int               pick;

		errors = 0;
		cycles = 0;
		items_sent = 0;
		results_checked = 0;
		writes_done = 0;
		seq_starts = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		clear_sequence();
		gap_reg = MAX_GAP_RESET;

		directed_rows.push_back(typed_row(1'b1, 32'd5, 48'd5, 47'd5));
		directed_rows.push_back(item_row(1'b0, -32'sd3));
		directed_rows.push_back(typed_row(1'b1, 32'h8000_0000, {16'hFFFF, 32'h8000_0000}, '0));
		directed_rows.push_back(item_row(1'b0, 32'h7FFF_FFFF));
		directed_rows.push_back(item_row(1'b0, 32'hFFFF_FFFF));
		directed_rows.push_back(typed_row(1'b1, 32'd0, '0, '0));
		// zero gap acts as one
		directed_rows.push_back(write_row(REG_MAX_GAP_ADDR, 32'd0));
		directed_rows.push_back(item_row(1'b0, 32'd3));
		directed_rows.push_back(item_row(1'b0, -32'sd7));
		directed_rows.push_back(item_row(1'b0, 32'd4));
		// bits above the field are dropped
		directed_rows.push_back(write_row(REG_MAX_GAP_ADDR, 32'hFFFF_FF82));
		directed_rows.push_back(typed_row(1'b1, 32'd10, 48'd10, 47'd10));
		directed_rows.push_back(item_row(1'b0, -32'sd20));
		directed_rows.push_back(item_row(1'b0, -32'sd20));
		directed_rows.push_back(item_row(1'b0, 32'd5));
		// gap above the window saturates
		directed_rows.push_back(write_row(REG_MAX_GAP_ADDR, 32'd127));
		directed_rows.push_back(typed_row(1'b1, 32'd100, 48'd100, 47'd100));
		directed_rows.push_back(item_row(1'b0, -32'sd50));
		directed_rows.push_back(item_row(1'b0, -32'sd60));
		directed_rows.push_back(item_row(1'b0, 32'd7));
		// write to an unmapped register is ignored
		directed_rows.push_back(write_row(UNUSED_REG_ADDR, 32'd1));
		directed_rows.push_back(item_row(1'b0, -32'sd1000));
		directed_rows.push_back(item_row(1'b0, 32'd1));
		directed_rows.push_back(write_row(REG_MAX_GAP_ADDR, 32'd64));
		directed_rows.push_back(item_row(1'b0, 32'h7FFF_FFFF));
		directed_rows.push_back(item_row(1'b0, 32'h7FFF_FFFF));
		directed_rows.push_back(item_row(1'b0, 32'h8000_0000));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				drain_results();
				apb_write(row.addr, row.data);
			end else begin
				tp.chain = row.chain;
				tp.best = row.best;
				send_item(row.start, row.data, row.typed, tp);
			end
		end

		tp.chain = '0;
		tp.best = '0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			case (phase)
				0: gapv = CFG_W'(1);
				1: gapv = CFG_W'(WIN);
				2: gapv = '0;
				3: gapv = '1;
				default: gapv = CFG_W'($urandom_range(0, 127));
			endcase
			wdata = $urandom();
			wdata[CFG_W-1:0] = gapv;
			apb_write(REG_MAX_GAP_ADDR, wdata);
			calm = (phase == 4);
			start_odds = phase[0] ? 8 : 150;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 6 && k == PHASE_ITEMS / 2)
					drain_results();
				pick = $urandom_range(0, 9);
				if (pick < 2)
					value = $urandom();
				else if (pick == 2)
					case ($urandom_range(0, 3))
						0: value = 32'h8000_0000;
						1: value = 32'h7FFF_FFFF;
						2: value = '0;
						default: value = '1;
					endcase
				else
					value = 32'($urandom_range(0, 3000)) - 32'd2000;
				send_item($urandom_range(0, start_odds) == 0, value, 1'b0, tp);
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_scores.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_scores.size()));
		$display("covered %0d requests in %0d sequences, %0d results checked",
			items_sent, seq_starts, results_checked);
		$display("%0d register writes over %0d random phases, %0d mismatches",
			writes_done, RANDOM_PHASES, errors);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
